>>> src/dsm_pkg.sv
package dsm_pkg;

    // fixed field widths
    localparam int CMD_W  = 3;
    localparam int DIAG_W = 4;
    localparam int POS_W  = 10;
    localparam int OFF_W  = 11;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 11;
    localparam int ND_W   = 5;
    localparam int CIDX_W = 3;

    // default sizes
    localparam int DEF_MAX_DIM   = 1024;
    localparam int DEF_MAX_DIAG  = 16;
    localparam int DEF_FRAC_BITS = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_OFF = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_VAL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_X   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_Y   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROW      = 3'd4;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_NUM_ROWS = 3'd0;
    localparam logic [CIDX_W-1:0] REG_NUM_COLS = 3'd1;
    localparam logic [CIDX_W-1:0] REG_NUM_DIAG = 3'd2;
    localparam logic [CIDX_W-1:0] REG_ALPHA    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_BETA     = 3'd4;

    // register reset values
    localparam logic [CNT_W-1:0] RST_NUM_ROWS = 11'd1024;
    localparam logic [CNT_W-1:0] RST_NUM_COLS = 11'd1024;
    localparam logic [ND_W-1:0]  RST_NUM_DIAG = 5'd0;
    localparam logic [VAL_W-1:0] RST_ALPHA    = 32'd65536;
    localparam logic [VAL_W-1:0] RST_BETA     = 32'd0;

    typedef enum logic [2:0] {
        K_OFF,
        K_VAL,
        K_X,
        K_Y,
        K_ROW
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [DIAG_W-1:0]        diag;
        logic [POS_W-1:0]         pos;
        logic [OFF_W-1:0]         offset;
        logic signed [VAL_W-1:0]  value;
    } t_op;

    typedef struct packed {
        logic [CNT_W-1:0]         num_columns;
        logic [ND_W-1:0]          num_diagonals;
        logic signed [VAL_W-1:0]  alpha;
        logic signed [VAL_W-1:0]  beta;
    } t_cfg;

endpackage

>>> src/dsm_in_if.sv
interface dsm_in_if;
    import dsm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [DIAG_W-1:0]       diag;
    logic [POS_W-1:0]        position;
    logic signed [OFF_W-1:0] offset;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, command, diag, position, offset, value, input ready);
    modport sink   (input valid, command, diag, position, offset, value, output ready);
endinterface

>>> src/dsm_out_if.sv
interface dsm_out_if;
    import dsm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        row;
    logic signed [VAL_W-1:0] result_value;
    logic                    overflow;

    modport source (output valid, row, result_value, overflow, input ready);
    modport sink   (input valid, row, result_value, overflow, output ready);
endinterface

>>> src/dsm_front.sv
module dsm_front #(
    parameter int MAX_DIM  = dsm_pkg::DEF_MAX_DIM,
    parameter int MAX_DIAG = dsm_pkg::DEF_MAX_DIAG
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    dsm_in_if.sink                   in_if,
    input  logic [dsm_pkg::CNT_W-1:0] i_num_rows,
    output logic                     o_q_valid,
    output dsm_pkg::t_op             o_q_op,
    input  logic                     i_q_pop
);
    import dsm_pkg::*;

    t_op        r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       keep;
    logic       push;
    t_op        op;
    logic [31:0] pos32;
    logic [31:0] dg32;
    logic       pos_ok;
    logic       dg_ok;

    assign pos32  = 32'(in_if.position);
    assign dg32   = 32'(in_if.diag);
    assign pos_ok = pos32 < 32'(MAX_DIM);
    assign dg_ok  = dg32 < 32'(MAX_DIAG);

    // classify, dropping items that cause nothing
    always_comb begin
        op.diag   = in_if.diag;
        op.pos    = in_if.position;
        op.offset = in_if.offset;
        op.value  = in_if.value;
        unique case (in_if.command)
            CMD_LOAD_OFF: begin
                op.kind = K_OFF;
                keep    = dg_ok;
            end
            CMD_LOAD_VAL: begin
                op.kind = K_VAL;
                keep    = dg_ok && pos_ok;
            end
            CMD_LOAD_X: begin
                op.kind = K_X;
                keep    = pos_ok;
            end
            CMD_LOAD_Y: begin
                op.kind = K_Y;
                keep    = pos_ok;
            end
            CMD_ROW: begin
                op.kind = K_ROW;
                keep    = pos_ok && (pos32 < 32'(i_num_rows));
            end
            default: begin
                op.kind = K_OFF;
                keep    = 1'b0;
            end
        endcase
    end

    assign in_if.ready = (r_cnt != 2'd2);
    assign push        = in_if.valid && in_if.ready && keep;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_op      = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            if (push && !i_q_pop) r_cnt <= r_cnt + 2'd1;
            else if (!push && i_q_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= op;
    end
endmodule

>>> src/dsm_back.sv
module dsm_back #(
    parameter int MAX_DIM   = dsm_pkg::DEF_MAX_DIM,
    parameter int MAX_DIAG  = dsm_pkg::DEF_MAX_DIAG,
    parameter int FRAC_BITS = dsm_pkg::DEF_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dsm_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  dsm_pkg::t_op  i_q_op,
    output logic          o_q_pop,
    dsm_out_if.source     out_if
);
    import dsm_pkg::*;

    localparam int AW     = $clog2(MAX_DIM);
    localparam int DW     = (MAX_DIAG > 1) ? $clog2(MAX_DIAG) : 1;
    localparam int CW     = $clog2(MAX_DIAG + 1);
    localparam int VDEPTH = 1 << (DW + AW);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DRAIN, S_M0, S_M1, S_M2, S_M3
    } t_state;

    t_state r_state;

    // storage
    logic [OFF_W-1:0]        r_offs [MAX_DIAG];
    logic signed [VAL_W-1:0] val_mem [VDEPTH];
    logic signed [VAL_W-1:0] x_mem [MAX_DIM];
    logic signed [VAL_W-1:0] y_mem [MAX_DIM];

    // current row
    logic [POS_W-1:0]        r_pos;
    logic [AW-1:0]           r_row;
    logic [CW-1:0]           r_d;

    // walk pipeline
    logic                    r_v1;
    logic                    r_v2;
    logic signed [VAL_W-1:0] r_dv;
    logic signed [VAL_W-1:0] r_xv;
    logic signed [63:0]      r_prod;
    logic signed [63:0]      r_acc;
    logic                    r_ov;

    // scaling
    logic signed [VAL_W-1:0] r_y;
    logic signed [64:0]      r_pa;
    logic signed [63:0]      r_pb;
    logic signed [63:0]      r_pc;
    logic signed [95:0]      r_sum;

    // result register
    logic                    r_ovalid;
    logic [POS_W-1:0]        r_orow;
    logic signed [VAL_W-1:0] r_ores;
    logic                    r_oov;

    logic [31:0]             p32;
    logic [AW-1:0]           q_addr;
    logic [31:0]             dg32;
    logic [DW-1:0]           q_dg;
    logic [31:0]             nd32;
    logic signed [31:0]      ncols32;
    logic signed [11:0]      j;
    logic signed [31:0]      j32;
    logic [31:0]             ju;
    logic [AW-1:0]           x_addr;
    logic [OFF_W-1:0]        cur_off;
    logic                    stop;
    logic                    take;
    logic                    issue;
    logic signed [63:0]      sh;
    logic signed [63:0]      asum;
    logic                    aovf;
    logic signed [97:0]      tot;
    logic                    in_rng;
    logic                    out_free;

    assign p32     = 32'(i_q_op.pos);
    assign q_addr  = p32[AW-1:0];
    assign dg32    = 32'(i_q_op.diag);
    assign q_dg    = dg32[DW-1:0];
    assign nd32    = (32'(i_cfg.num_diagonals) > 32'(MAX_DIAG)) ? 32'(MAX_DIAG)
                                                                 : 32'(i_cfg.num_diagonals);
    assign ncols32 = (32'(i_cfg.num_columns) > 32'(MAX_DIM)) ? 32'(MAX_DIM)
                                                               : 32'(i_cfg.num_columns);
    assign cur_off = r_offs[r_d[DW-1:0]];
    assign j       = $signed({2'b00, r_pos}) + $signed({cur_off[OFF_W-1], cur_off});
    assign j32     = 32'(j);
    assign ju      = j32;
    assign x_addr  = ju[AW-1:0];
    assign stop    = (32'(r_d) >= nd32) || (j32 >= ncols32);
    assign issue   = (r_state == S_WALK) && !stop && !j[11];
    assign take    = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop = take;

    assign sh   = r_prod >>> FRAC_BITS;
    assign asum = r_acc + sh;
    assign aovf = (r_acc[63] == sh[63]) && (asum[63] != r_acc[63]);

    assign tot    = 98'(r_sum >>> FRAC_BITS) + 98'(r_pc >>> FRAC_BITS);
    assign in_rng = (tot[97:31] == '0) || (tot[97:31] == '1);

    assign out_free = !r_ovalid || out_if.ready;

    // memories
    always_ff @(posedge i_clk) begin
        if (take && i_q_op.kind == K_OFF) r_offs[q_dg] <= i_q_op.offset;
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_op.kind == K_VAL) val_mem[{q_dg, q_addr}] <= i_q_op.value;
        r_dv <= val_mem[{r_d[DW-1:0], r_row}];
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_op.kind == K_X) x_mem[q_addr] <= i_q_op.value;
        r_xv <= x_mem[x_addr];
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_op.kind == K_Y) y_mem[q_addr] <= i_q_op.value;
        r_y <= y_mem[r_row];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= r_dv * r_xv;
        if (r_state == S_M0) r_pa <= $signed({1'b0, r_acc[31:0]}) * i_cfg.alpha;
        if (r_state == S_M1) r_pb <= $signed(r_acc[63:32]) * i_cfg.alpha;
        if (r_state == S_M2) begin
            r_pc  <= i_cfg.beta * r_y;
            r_sum <= $signed({r_pb, 32'd0}) + 96'(r_pa);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ovalid <= 1'b0;
            r_d      <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (r_ovalid && out_if.ready && r_state != S_M3) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take && i_q_op.kind == K_ROW) begin
                        r_pos   <= i_q_op.pos;
                        r_row   <= q_addr;
                        r_d     <= '0;
                        r_acc   <= '0;
                        r_ov    <= 1'b0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (stop) r_state <= S_DRAIN;
                    else r_d <= r_d + CW'(1);
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) r_state <= S_M0;
                end
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_orow   <= r_pos;
                        r_oov    <= r_ov || !in_rng;
                        if (in_rng) r_ores <= tot[31:0];
                        else if (tot[97]) r_ores <= 32'sh8000_0000;
                        else r_ores <= 32'sh7fff_ffff;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_v2) begin
                if (aovf) begin
                    r_ov  <= 1'b1;
                    r_acc <= r_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    r_acc <= asum;
                end
            end
        end
    end

    assign out_if.valid        = r_ovalid;
    assign out_if.row          = r_orow;
    assign out_if.result_value = r_ores;
    assign out_if.overflow     = r_oov;
endmodule

>>> src/dia_sparse_matvec_core.sv
// load items are written to the stores as the back end takes them; a compute item
// walks its diagonals (one multiply-accumulate a cycle) through the take, read,
// multiply and drain stages, then runs the scaling and saturation states M0 to M3
// a two-entry queue lets the front take items while the back is busy
// synchronous active-low reset clears control and config registers; the
// stores hold no reset and must be written before they are read
module dia_sparse_matvec_core #(
    parameter int MAX_DIM   = dsm_pkg::DEF_MAX_DIM,
    parameter int MAX_DIAG  = dsm_pkg::DEF_MAX_DIAG,
    parameter int FRAC_BITS = dsm_pkg::DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dsm_in_if.sink                    in_if,
    dsm_out_if.source                 out_if,
    input  logic                      i_cfg_we,
    input  logic [dsm_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [dsm_pkg::VAL_W-1:0]  i_cfg_data
);
    import dsm_pkg::*;

    // configuration registers
    logic [CNT_W-1:0]        r_num_rows;
    logic [CNT_W-1:0]        r_num_cols;
    logic [ND_W-1:0]         r_num_diag;
    logic signed [VAL_W-1:0] r_alpha;
    logic signed [VAL_W-1:0] r_beta;

    t_cfg cfg;
    logic q_valid;
    t_op  q_op;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= RST_NUM_ROWS;
            r_num_cols <= RST_NUM_COLS;
            r_num_diag <= RST_NUM_DIAG;
            r_alpha    <= RST_ALPHA;
            r_beta     <= RST_BETA;
        end else if (i_cfg_we) begin
            // writes beyond the last register fall through and are dropped
            unique case (i_cfg_idx)
                REG_NUM_ROWS: r_num_rows <= i_cfg_data[CNT_W-1:0];
                REG_NUM_COLS: r_num_cols <= i_cfg_data[CNT_W-1:0];
                REG_NUM_DIAG: r_num_diag <= i_cfg_data[ND_W-1:0];
                REG_ALPHA:    r_alpha    <= i_cfg_data;
                REG_BETA:     r_beta     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.num_columns   = r_num_cols;
    assign cfg.num_diagonals = r_num_diag;
    assign cfg.alpha         = r_alpha;
    assign cfg.beta          = r_beta;

    // front: accepts items, drops those that cause nothing, queues the rest
    dsm_front #(
        .MAX_DIM  (MAX_DIM),
        .MAX_DIAG (MAX_DIAG)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_if      (in_if),
        .i_num_rows (r_num_rows),
        .o_q_valid  (q_valid),
        .o_q_op     (q_op),
        .i_q_pop    (q_pop)
    );

    // back: applies loads, walks diagonals, scales and saturates
    dsm_back #(
        .MAX_DIM   (MAX_DIM),
        .MAX_DIAG  (MAX_DIAG),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_q_pop   (q_pop),
        .out_if    (out_if)
    );

    // no result survives a reset
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !out_if.valid)
        else $error("result valid after reset");

    // only rows inside the configured range ever produce a result
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid |-> ({1'b0, out_if.row} < r_num_rows))
        else $error("result for row outside range");

    // queue is never popped while empty
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
endmodule
